// ===== sv/ihp_pkg.sv =====
// Shared constants, command codes and transfer structs of the indexed min-heap.
package ihp_pkg;

	localparam int CAPACITY_DEF  = 256;
	localparam int DIST_BITS_DEF = 16;

	localparam int CMD_W        = 2;
	localparam int NODE_W       = 8;
	localparam int DIST_W       = 16;
	localparam int NODE_COUNT_W = 9;
	localparam int LEFT_W       = 9;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;

	localparam logic [CMD_W-1:0] CMD_FILL    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEC_KEY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INF_DIST   = 1'd1;

	localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 9'd256;
	localparam logic [DIST_W-1:0]       INF_DIST_RESET   = 16'd10000;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [NODE_W-1:0] node_id;
		logic [DIST_W-1:0] new_distance;
	} ihp_cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0] out_node;
		logic [DIST_W-1:0] out_distance;
		logic              found;
		logic [LEFT_W-1:0] entries_left;
	} ihp_res_t;

endpackage

// ===== sv/ihp_if.sv =====
// Valid/ready channel interfaces for commands, results and configuration writes.
interface ihp_req_if;
	logic                        valid;
	logic                        ready;
	logic [ihp_pkg::CMD_W-1:0]   cmd;
	logic [ihp_pkg::NODE_W-1:0]  node_id;
	logic [ihp_pkg::DIST_W-1:0]  new_distance;

	modport source (output valid, cmd, node_id, new_distance, input ready);
	modport sink (input valid, cmd, node_id, new_distance, output ready);
endinterface

interface ihp_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ihp_pkg::NODE_W-1:0]  out_node;
	logic [ihp_pkg::DIST_W-1:0]  out_distance;
	logic                        found;
	logic [ihp_pkg::LEFT_W-1:0]  entries_left;

	modport source (output valid, out_node, out_distance, found, entries_left, input ready);
	modport sink (input valid, out_node, out_distance, found, entries_left, output ready);
endinterface

interface ihp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ihp_pkg::CFG_IDX_W-1:0]  index;
	logic [ihp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/indexed_min_heap.sv =====
// Top level of the indexed min-heap: configuration registers, command intake, result register.
//
//   channel  role      transfer carries
//   cfg      sink      index, data (register write)
//   req      sink      cmd, node_id, new_distance
//   rsp      source    out_node, out_distance, found, entries_left
//
// One command is in work at a time; req.ready is high only while the sequencer is idle.
// Query, and decrease key on an absent node: position lookup, then result. Decrease key: lookup, then a read and
// a compare per parent, then the placing write. Extract: result at once when empty, else root and last reads, then
// child reads, compares, a write per level. Fill: one position-memory entry per cycle, min(CAPACITY, 512) in all.
// Both memories have one read and one write port; that port count sets the per-level cost.
// The result register frees the sequencer as soon as rsp can take it; reset empties the heap.
module indexed_min_heap #(
	parameter int CAPACITY  = ihp_pkg::CAPACITY_DEF,
	parameter int DIST_BITS = ihp_pkg::DIST_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ihp_cfg_if.sink   cfg,
	ihp_req_if.sink   req,
	ihp_rsp_if.source rsp
);
	import ihp_pkg::*;

	logic [NODE_COUNT_W-1:0] node_count_q;
	logic [DIST_BITS-1:0]    inf_dist_q;
	logic                    rsp_valid_q;
	ihp_res_t                rsp_q;

	ihp_cmd_t cmd_in;
	ihp_res_t core_res;
	logic     core_idle;
	logic     core_res_valid;
	logic     core_res_ready;
	logic     start;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
			inf_dist_q   <= DIST_BITS'(INF_DIST_RESET);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_NODE_COUNT: node_count_q <= cfg.data[NODE_COUNT_W-1:0];
				REG_INF_DIST:   inf_dist_q   <= DIST_BITS'(cfg.data);
				default: begin
				end
			endcase
		end
	end

	assign req.ready           = core_idle;
	assign start               = req.valid && core_idle;
	assign cmd_in.cmd          = req.cmd;
	assign cmd_in.node_id      = req.node_id;
	assign cmd_in.new_distance = req.new_distance;

	ihp_core #(
		.CAPACITY  (CAPACITY),
		.DIST_BITS (DIST_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd_in     (cmd_in),
		.node_count (node_count_q),
		.inf_dist   (inf_dist_q),
		.idle       (core_idle),
		.res_valid  (core_res_valid),
		.res_ready  (core_res_ready),
		.res        (core_res)
	);

	assign core_res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (core_res_valid && core_res_ready) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= core_res;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.out_node     = rsp_q.out_node;
	assign rsp.out_distance = rsp_q.out_distance;
	assign rsp.found        = rsp_q.found;
	assign rsp.entries_left = rsp_q.entries_left;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("command intake stayed open after a command transfer");

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> 32'(rsp.entries_left) <= CAPACITY)
		else $error("heap size exceeds capacity");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.out_node == '0 && rsp.out_distance == '0)
		else $error("result without a hit carries a node or distance");
`endif

endmodule

// ===== sv/ihp_core.sv =====
// Heap sequencer: slot and position memories, one shared distance comparator.
module ihp_core #(
	parameter int CAPACITY  = ihp_pkg::CAPACITY_DEF,
	parameter int DIST_BITS = ihp_pkg::DIST_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  ihp_pkg::ihp_cmd_t                 cmd_in,
	input  logic [ihp_pkg::NODE_COUNT_W-1:0]  node_count,
	input  logic [DIST_BITS-1:0]              inf_dist,
	output logic                              idle,
	output logic                              res_valid,
	input  logic                              res_ready,
	output ihp_pkg::ihp_res_t                 res
);
	import ihp_pkg::*;

	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int SIZE_W   = $clog2(CAPACITY + 1);
	localparam int NS_DEPTH = (CAPACITY < (2 ** NODE_COUNT_W)) ? CAPACITY : (2 ** NODE_COUNT_W);
	localparam int NW       = $clog2(NS_DEPTH);
	localparam int CH_W     = SLOT_W + 2;
	localparam int ENT_W    = NW + DIST_BITS;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_FILL    = 4'd1;
	localparam logic [3:0] ST_MEMB    = 4'd2;
	localparam logic [3:0] ST_UP_RD   = 4'd3;
	localparam logic [3:0] ST_UP_CMP  = 4'd4;
	localparam logic [3:0] ST_PLACE   = 4'd5;
	localparam logic [3:0] ST_EX_ROOT = 4'd6;
	localparam logic [3:0] ST_EX_LAST = 4'd7;
	localparam logic [3:0] ST_DN_RD   = 4'd8;
	localparam logic [3:0] ST_DN_L    = 4'd9;
	localparam logic [3:0] ST_DN_R    = 4'd10;
	localparam logic [3:0] ST_DN_W    = 4'd11;
	localparam logic [3:0] ST_DONE    = 4'd12;

	logic [3:0]            state_q;
	logic [CMD_W-1:0]      op_q;
	logic [NODE_W-1:0]     node_q;
	logic [NW-1:0]         cur_node_q;
	logic [DIST_BITS-1:0]  cur_dist_q;
	logic [SLOT_W-1:0]     idx_q;
	logic [SIZE_W-1:0]     size_q;
	logic                  best_child_q;
	logic [SLOT_W-1:0]     best_idx_q;
	logic [NW-1:0]         best_node_q;
	logic [DIST_BITS-1:0]  best_dist_q;
	logic [NW-1:0]         fill_q;
	logic [SIZE_W-1:0]     fill_n_q;
	logic [NW-1:0]         res_node_q;
	logic [DIST_BITS-1:0]  res_dist_q;
	logic                  found_q;

	logic [ENT_W-1:0]  slot_mem [CAPACITY];
	logic [SLOT_W-1:0] ns_mem [NS_DEPTH];
	logic [ENT_W-1:0]  slot_rdata;
	logic [SLOT_W-1:0] ns_rdata;

	logic              slot_we;
	logic [SLOT_W-1:0] slot_waddr;
	logic [ENT_W-1:0]  slot_wdata;
	logic [SLOT_W-1:0] slot_raddr;
	logic              ns_we;
	logic [NW-1:0]     ns_waddr;
	logic [SLOT_W-1:0] ns_wdata;
	logic [NW-1:0]     ns_raddr;

	logic [NW-1:0]        rd_node;
	logic [DIST_BITS-1:0] rd_dist;
	logic [DIST_BITS-1:0] cmp_a;
	logic [DIST_BITS-1:0] cmp_b;
	logic                 less;
	logic [SLOT_W-1:0]    parent_idx;
	logic [CH_W-1:0]      left_w;
	logic [CH_W-1:0]      right_w;
	logic                 left_ok;
	logic                 right_ok;
	logic                 fill_lt;
	logic [SIZE_W-1:0]    fill_n;
	logic                 member;

	assign rd_node    = slot_rdata[ENT_W-1:DIST_BITS];
	assign rd_dist    = slot_rdata[DIST_BITS-1:0];
	assign parent_idx = (idx_q - SLOT_W'(1)) >> 1;
	assign left_w     = {1'b0, idx_q, 1'b1};
	assign right_w    = {1'b0, idx_q, 1'b0} + CH_W'(2);
	assign left_ok    = left_w < CH_W'(size_q);
	assign right_ok   = right_w < CH_W'(size_q);
	assign fill_lt    = SIZE_W'(fill_q) < fill_n_q;
	assign fill_n     = (32'(node_count) > CAPACITY) ? SIZE_W'(CAPACITY) : SIZE_W'(node_count);
	assign member     = (size_q != '0) && (32'(node_q) < CAPACITY)
		&& (SIZE_W'(ns_rdata) < size_q);

	// The single distance comparator, shared by sift up and both child checks of sift down.
	assign cmp_a = (state_q == ST_UP_CMP) ? cur_dist_q : rd_dist;
	assign cmp_b = (state_q == ST_UP_CMP) ? rd_dist
		: ((state_q == ST_DN_R) ? best_dist_q : cur_dist_q);
	assign less  = cmp_a < cmp_b;

	assign ns_raddr = NW'(cmd_in.node_id);

	always_comb begin
		unique case (state_q)
			ST_EX_ROOT: slot_raddr = SLOT_W'(size_q - SIZE_W'(1));
			ST_UP_RD:   slot_raddr = parent_idx;
			ST_DN_RD:   slot_raddr = SLOT_W'(left_w);
			ST_DN_L:    slot_raddr = SLOT_W'(right_w);
			default:    slot_raddr = '0;
		endcase
	end

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = idx_q;
		slot_wdata = {cur_node_q, cur_dist_q};
		ns_we      = 1'b0;
		ns_waddr   = cur_node_q;
		ns_wdata   = idx_q;
		unique case (state_q)
			ST_FILL: begin
				slot_we    = fill_lt;
				slot_waddr = SLOT_W'(fill_q);
				slot_wdata = {fill_q, inf_dist};
				ns_we      = 1'b1;
				ns_waddr   = fill_q;
				ns_wdata   = fill_lt ? SLOT_W'(fill_q) : SLOT_W'(CAPACITY - 1);
			end
			ST_UP_CMP: begin
				slot_we    = less;
				slot_wdata = slot_rdata;
				ns_we      = less;
				ns_waddr   = rd_node;
			end
			ST_PLACE: begin
				slot_we = 1'b1;
				ns_we   = 1'b1;
			end
			ST_EX_LAST: begin
				ns_we    = 1'b1;
				ns_waddr = res_node_q;
				ns_wdata = SLOT_W'(size_q - SIZE_W'(1));
			end
			ST_DN_W: begin
				slot_we    = best_child_q;
				slot_wdata = {best_node_q, best_dist_q};
				ns_we      = best_child_q;
				ns_waddr   = best_node_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		slot_rdata <= slot_mem[slot_raddr];
	end

	always_ff @(posedge clk) begin
		if (ns_we) begin
			ns_mem[ns_waddr] <= ns_wdata;
		end
		ns_rdata <= ns_mem[ns_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= CMD_FILL;
			node_q       <= '0;
			cur_node_q   <= '0;
			cur_dist_q   <= '0;
			idx_q        <= '0;
			size_q       <= '0;
			best_child_q <= 1'b0;
			best_idx_q   <= '0;
			best_node_q  <= '0;
			best_dist_q  <= '0;
			fill_q       <= '0;
			fill_n_q     <= '0;
			res_node_q   <= '0;
			res_dist_q   <= '0;
			found_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q       <= cmd_in.cmd;
						node_q     <= cmd_in.node_id;
						cur_node_q <= NW'(cmd_in.node_id);
						cur_dist_q <= DIST_BITS'(cmd_in.new_distance);
						res_node_q <= '0;
						res_dist_q <= '0;
						found_q    <= 1'b0;
						fill_q     <= '0;
						fill_n_q   <= fill_n;
						unique case (cmd_in.cmd)
							CMD_FILL:    state_q <= ST_FILL;
							CMD_EXTRACT: state_q <= (size_q == '0) ? ST_DONE : ST_EX_ROOT;
							default:     state_q <= ST_MEMB;
						endcase
					end
				end
				ST_FILL: begin
					if (fill_q == NW'(NS_DEPTH - 1)) begin
						size_q  <= fill_n_q;
						state_q <= ST_DONE;
					end else begin
						fill_q <= fill_q + NW'(1);
					end
				end
				ST_MEMB: begin
					if (op_q == CMD_QUERY) begin
						found_q <= member;
						state_q <= ST_DONE;
					end else if (member) begin
						found_q <= 1'b1;
						idx_q   <= ns_rdata;
						state_q <= (ns_rdata == '0) ? ST_PLACE : ST_UP_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_UP_RD: begin
					state_q <= ST_UP_CMP;
				end
				ST_UP_CMP: begin
					if (less) begin
						idx_q   <= parent_idx;
						state_q <= (parent_idx == '0) ? ST_PLACE : ST_UP_RD;
					end else begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					state_q <= ST_DONE;
				end
				ST_EX_ROOT: begin
					res_node_q <= rd_node;
					res_dist_q <= rd_dist;
					found_q    <= 1'b1;
					state_q    <= ST_EX_LAST;
				end
				ST_EX_LAST: begin
					cur_node_q <= rd_node;
					cur_dist_q <= rd_dist;
					size_q     <= size_q - SIZE_W'(1);
					idx_q      <= '0;
					state_q    <= (size_q == SIZE_W'(1)) ? ST_DONE : ST_DN_RD;
				end
				ST_DN_RD: begin
					state_q <= left_ok ? ST_DN_L : ST_PLACE;
				end
				ST_DN_L: begin
					best_child_q <= less;
					best_idx_q   <= SLOT_W'(left_w);
					best_node_q  <= rd_node;
					best_dist_q  <= less ? rd_dist : cur_dist_q;
					state_q      <= right_ok ? ST_DN_R : ST_DN_W;
				end
				ST_DN_R: begin
					if (less) begin
						best_child_q <= 1'b1;
						best_idx_q   <= SLOT_W'(right_w);
						best_node_q  <= rd_node;
						best_dist_q  <= rd_dist;
					end
					state_q <= ST_DN_W;
				end
				ST_DN_W: begin
					if (best_child_q) begin
						idx_q   <= best_idx_q;
						state_q <= ST_DN_RD;
					end else begin
						state_q <= ST_PLACE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle             = state_q == ST_IDLE;
	assign res_valid        = state_q == ST_DONE;
	assign res.out_node     = NODE_W'(res_node_q);
	assign res.out_distance = DIST_W'(res_dist_q);
	assign res.found        = found_q;
	assign res.entries_left = LEFT_W'(size_q);

endmodule
